// ===== design/integer_array_sorter_core_assert.svh =====
// Assertion macros used by the checker of the sorter.
`ifndef INTEGER_ARRAY_SORTER_CORE_ASSERT_SVH
`define INTEGER_ARRAY_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ISAS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorter check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ISAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorter check failed");

`endif

// ===== design/isas_pkg.sv =====
package isas_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// What one cell shows its neighbors.
	typedef struct packed {
		logic                     valid;
		logic                     lt;
		logic signed [DATA_W-1:0] value;
	} cell_link_t;

	// Commands broadcast along the row.
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== design/isas_cell.sv =====
module isas_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  isas_pkg::cell_ctrl_t              ctrl,
	input  logic signed [isas_pkg::DATA_W-1:0] new_value,
	input  isas_pkg::cell_link_t              prev_link,
	input  isas_pkg::cell_link_t              next_link,
	output isas_pkg::cell_link_t              link
);
	import isas_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     lt;

	// An empty cell counts as +infinity, so empty cells always take part in the shift.
	assign lt = !valid_q || (new_value < value_q);

	assign link.valid = valid_q;
	assign link.lt    = lt;
	assign link.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_link.valid;
		end else if (ctrl.insert && lt) begin
			valid_q <= prev_link.lt ? prev_link.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_link.value;
		end else if (ctrl.insert && lt) begin
			// Take the new value at the insertion point, make room behind it.
			value_q <= prev_link.lt ? prev_link.value : new_value;
		end
	end

endmodule

// ===== design/integer_array_sorter_core.sv =====
// Streaming integer sorter. Signed 32-bit values enter one transaction per cycle and
// are placed in order as they arrive, in a row of MAX_ELEMS compare-and-shift cells.
// The transaction with last set closes the set; the block then drains the row, smallest
// value first, one result transaction per cycle while result_ready is high, with
// final_res on the largest. While draining, item_ready is low. Values that
// arrive with the row full are discarded, and every result of that set carries overflow.
module integer_array_sorter_core #(
	parameter int unsigned MAX_ELEMS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [isas_pkg::DATA_W-1:0] value,
	input  logic                               last,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [isas_pkg::DATA_W-1:0] sorted_value,
	output logic                               final_res,
	output logic                               overflow
);
	import isas_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1);

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q;
	logic                 dropped_q;
	logic                 full;
	logic                 item_acc;
	logic                 result_acc;
	logic                 drain_done;
	cell_ctrl_t           ctrl;
	cell_link_t           links [MAX_ELEMS];

	assign full       = (count_q == CNT_W'(MAX_ELEMS));
	assign item_acc   = item_valid && item_ready;
	assign result_acc = result_valid && result_ready;
	assign drain_done = result_acc && final_res;

	always_comb begin
		state_d      = state_q;
		item_ready   = 1'b0;
		result_valid = 1'b0;
		ctrl.insert  = 1'b0;
		ctrl.shift   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				item_ready  = 1'b1;
				ctrl.insert = item_valid && !full;
				if (item_valid && last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				result_valid = links[0].valid;
				ctrl.shift   = result_ready;
				if (drain_done || !links[0].valid) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRAIN && state_d == ST_LOAD) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else if (item_acc) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
		cell_link_t prev_link;
		cell_link_t next_link;

		if (i == 0) begin : g_head
			// Head has no left neighbor: at the insertion point it takes the new value.
			assign prev_link = '{valid: 1'b1, lt: 1'b0, value: '0};
		end else begin : g_body
			assign prev_link = links[i-1];
		end

		if (i == MAX_ELEMS - 1) begin : g_tail
			assign next_link = '{valid: 1'b0, lt: 1'b1, value: '0};
		end else begin : g_mid
			assign next_link = links[i+1];
		end

		isas_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_value (value),
			.prev_link (prev_link),
			.next_link (next_link),
			.link      (links[i])
		);
	end

	assign sorted_value = links[0].value;
	assign final_res    = !links[1].valid;
	assign overflow     = dropped_q;

endmodule

// ===== design/isas_checker.sv =====
`include "integer_array_sorter_core_assert.svh"

module isas_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic                               last,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic signed [isas_pkg::DATA_W-1:0] sorted_value,
	input logic                               final_res,
	input logic                               overflow
);
	import isas_pkg::*;

	logic item_acc;
	logic result_acc;

	assign item_acc   = item_valid && item_ready;
	assign result_acc = result_valid && result_ready;

	// Loading and draining never overlap.
	`ISAS_ASSERT_NOW(a_no_overlap, 1'b1, !(item_ready && result_valid))
	// Closing a set starts the drain at once.
	`ISAS_ASSERT_NEXT(a_drain_starts, item_acc && last, result_valid && !item_ready)
	// Results come out in ascending order.
	`ISAS_ASSERT_NEXT(a_ascending, result_acc && !final_res,
		result_valid && (sorted_value >= $past(sorted_value)))
	// The final result ends the set.
	`ISAS_ASSERT_NEXT(a_final_ends, result_acc && final_res, !result_valid && item_ready)
	// Hold a stalled result transaction.
	`ISAS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(sorted_value) && $stable(final_res) && $stable(overflow))

endmodule

bind integer_array_sorter_core isas_checker u_isas_checker (.*);
